// ===== src/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// types and constants shared by the grid broad-phase collision counter
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned COORD_W    = 16;  // signed q12.4 corner
  localparam int unsigned SIZE_W     = 15;  // unsigned q11.4 extent
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned HIT_W      = 4;
  localparam int unsigned GRID_CELLS = 8;
  localparam int unsigned CELL_IDX_W = 3;
  localparam int unsigned EDGE_W     = 19;  // wide enough for far cell edges
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [HIT_W-1:0] HIT_MAX = 4'd15;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'b1;

  // request kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } rect_t;

  typedef struct packed {
    logic [HIT_W-1:0]      hits;
    logic [GRID_CELLS-1:0] mask;
    logic [SIZE_W-1:0]     height;
    logic [SIZE_W-1:0]     width;
    logic [COORD_W-1:0]    top;
    logic [COORD_W-1:0]    left;
    logic [TAG_W-1:0]      tag;
  } box_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_STORE,
    ST_EMPTY,
    ST_RD_I,
    ST_LATCH_I,
    ST_RD_J,
    ST_CMP_J,
    ST_REPORT
  } state_e;

  function automatic rect_t rec_rect(box_rec_t rec);
    rect_t r;
    r.left   = {{(EDGE_W - COORD_W){rec.left[COORD_W-1]}}, rec.left};
    r.top    = {{(EDGE_W - COORD_W){rec.top[COORD_W-1]}}, rec.top};
    r.width  = rec.width;
    r.height = rec.height;
    return r;
  endfunction

endpackage

// ===== src/gbc_ram.sv =====
// ----------------------------------------------------------------------------
// gbc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/gbc_overlap.sv =====
// ----------------------------------------------------------------------------
// gbc_overlap
// strict positive-area overlap test of two rectangles, shared by cell
// marking and pair testing
// ----------------------------------------------------------------------------
module gbc_overlap (
  input  gbc_pkg::rect_t a_i,
  input  gbc_pkg::rect_t b_i,
  output logic           hit_o
);

  logic signed [gbc_pkg::EDGE_W-1:0] a_r, a_b, b_r, b_b;
  logic                              sizes_ok, x_ok, y_ok;

  assign a_r = $signed(a_i.left) + $signed({4'b0, a_i.width});
  assign a_b = $signed(a_i.top) + $signed({4'b0, a_i.height});
  assign b_r = $signed(b_i.left) + $signed({4'b0, b_i.width});
  assign b_b = $signed(b_i.top) + $signed({4'b0, b_i.height});

  // empty spans never overlap, even when nested inside the other box
  assign sizes_ok = (a_i.width != '0) && (a_i.height != '0) &&
                    (b_i.width != '0) && (b_i.height != '0);
  assign x_ok = ($signed(a_i.left) < b_r) && ($signed(b_i.left) < a_r);
  assign y_ok = ($signed(a_i.top) < b_b) && ($signed(b_i.top) < a_b);

  assign hit_o = sizes_ok && x_ok && y_ok;

endmodule

// ===== src/grid_broadphase_collision_counter.sv =====
// ----------------------------------------------------------------------------
// grid_broadphase_collision_counter
// stores boxes with their grid cell masks, then counts strict overlaps of
// every pair sharing a cell and reports one count per box in load order
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: tag, left, top, width, height
//           |     |                              | tuser: command
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: report_tag, hit_count
//           |     |                              | tuser: overflow, empty_run; tlast: last
//  cfg      | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// a load accepts the box, passes each grid cell through the overlap unit in
// turn, then writes the store; a load into a full store is dropped and flags overflow
// a run reads each box i, then reads, compares and writes back every later box j
// in turn through the single ram read port and the shared overlap unit
// an empty run gives one empty report; reset empties the store and loads 1024 into
// both cell sizes; a stalled output freezes the pair walk at the next report
// ----------------------------------------------------------------------------
module grid_broadphase_collision_counter #(
  parameter int unsigned MAX_BOXES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] entity_tag, [31:16] box_left, [47:32] box_top,
  // [62:48] box_width, [77:63] box_height, [79:78] zero
  input  logic [79:0]                    s_axis_tdata,
  // [0] command
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] report_tag, [19:16] hit_count, [23:20] zero
  output logic [23:0]                    m_axis_tdata,
  // [0] overflow, [1] empty_run
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbc_pkg::SIZE_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

  gbc_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              dropped_q, dropped_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [gbc_pkg::CELL_IDX_W-1:0] k_q, k_d;
  logic [gbc_pkg::SIZE_W-1:0]     cell_w_q, cell_h_q;

  gbc_pkg::box_rec_t cur_q, cur_d;

  logic                        out_valid_q, out_valid_d;
  logic [gbc_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  logic [gbc_pkg::HIT_W-1:0]   out_hit_q, out_hit_d;
  logic                        out_ovf_q, out_ovf_d;
  logic                        out_empty_q, out_empty_d;
  logic                        out_last_q, out_last_d;
  logic                        out_free;
  logic                        out_load;

  logic                        in_fire;
  gbc_pkg::box_rec_t           in_rec;

  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  gbc_pkg::box_rec_t           ram_wdata, ram_rdata;

  gbc_pkg::rect_t              ov_a, ov_b, cell_rect;
  logic                        ov_hit;
  logic [gbc_pkg::EDGE_W-1:0]  cell_x;
  logic                        pair_hit;
  gbc_pkg::box_rec_t           j_upd;

  // ---------------------------------------------------------------------------
  // request decode

  assign s_axis_tready = (state_q == gbc_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_rec        = '0;
    in_rec.tag    = s_axis_tdata[15:0];
    in_rec.left   = s_axis_tdata[31:16];
    in_rec.top    = s_axis_tdata[47:32];
    in_rec.width  = s_axis_tdata[62:48];
    in_rec.height = s_axis_tdata[77:63];
  end

  // ---------------------------------------------------------------------------
  // cell k rectangle: column k mod 4, row k div 4

  always_comb begin
    unique case (k_q[1:0])
      2'd0:    cell_x = '0;
      2'd1:    cell_x = {4'b0, cell_w_q};
      2'd2:    cell_x = {3'b0, cell_w_q, 1'b0};
      default: cell_x = {4'b0, cell_w_q} + {3'b0, cell_w_q, 1'b0};
    endcase
    cell_rect.left   = cell_x;
    cell_rect.top    = k_q[2] ? {4'b0, cell_h_q} : '0;
    cell_rect.width  = cell_w_q;
    cell_rect.height = cell_h_q;
  end

  // shared overlap unit: box vs cell while loading, box i vs box j in a run
  always_comb begin
    ov_a = gbc_pkg::rec_rect(cur_q);
    ov_b = (state_q == gbc_pkg::ST_CELL) ? cell_rect : gbc_pkg::rec_rect(ram_rdata);
  end

  gbc_overlap u_overlap (
    .a_i   (ov_a),
    .b_i   (ov_b),
    .hit_o (ov_hit)
  );

  assign pair_hit = ov_hit && ((cur_q.mask & ram_rdata.mask) != '0);

  always_comb begin
    j_upd = ram_rdata;
    if (pair_hit && ram_rdata.hits != gbc_pkg::HIT_MAX) begin
      j_upd.hits = ram_rdata.hits + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cur_d       = cur_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = count_q[IDX_W-1:0];
    ram_raddr   = i_q[IDX_W-1:0];
    ram_wdata   = cur_q;
    out_load    = 1'b0;
    out_tag_d   = out_tag_q;
    out_hit_d   = out_hit_q;
    out_ovf_d   = out_ovf_q;
    out_empty_d = out_empty_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      gbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser[0] == gbc_pkg::CMD_RUN) begin
            i_d     = '0;
            state_d = (count_q == '0) ? gbc_pkg::ST_EMPTY : gbc_pkg::ST_RD_I;
          end else if (count_q == CNT_MAX) begin
            dropped_d = 1'b1;
          end else begin
            cur_d   = in_rec;
            k_d     = '0;
            state_d = gbc_pkg::ST_CELL;
          end
        end
      end

      gbc_pkg::ST_CELL: begin
        cur_d.mask[k_q] = ov_hit;
        k_d             = k_q + 1'b1;
        if (k_q == gbc_pkg::CELL_IDX_W'(gbc_pkg::GRID_CELLS - 1)) begin
          state_d = gbc_pkg::ST_STORE;
        end
      end

      gbc_pkg::ST_STORE: begin
        ram_we  = 1'b1;
        count_d = count_q + 1'b1;
        state_d = gbc_pkg::ST_IDLE;
      end

      gbc_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_tag_d   = '0;
          out_hit_d   = '0;
          out_ovf_d   = 1'b0;
          out_empty_d = 1'b1;
          out_last_d  = 1'b1;
          dropped_d   = 1'b0;
          state_d     = gbc_pkg::ST_IDLE;
        end
      end

      gbc_pkg::ST_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[IDX_W-1:0];
        state_d   = gbc_pkg::ST_LATCH_I;
      end

      gbc_pkg::ST_LATCH_I: begin
        // box i carries the hits it got from earlier boxes
        cur_d   = ram_rdata;
        j_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 == count_q) ? gbc_pkg::ST_REPORT : gbc_pkg::ST_RD_J;
      end

      gbc_pkg::ST_RD_J: begin
        ram_re    = 1'b1;
        ram_raddr = j_q[IDX_W-1:0];
        state_d   = gbc_pkg::ST_CMP_J;
      end

      gbc_pkg::ST_CMP_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IDX_W-1:0];
        ram_wdata = j_upd;
        if (pair_hit && cur_q.hits != gbc_pkg::HIT_MAX) begin
          cur_d.hits = cur_q.hits + 1'b1;
        end
        j_d     = j_q + 1'b1;
        state_d = (j_q + 1'b1 == count_q) ? gbc_pkg::ST_REPORT : gbc_pkg::ST_RD_J;
      end

      gbc_pkg::ST_REPORT: begin
        // count of box i is final once its own pairs are walked
        if (out_free) begin
          out_load    = 1'b1;
          out_tag_d   = cur_q.tag;
          out_hit_d   = cur_q.hits;
          out_ovf_d   = dropped_q;
          out_empty_d = 1'b0;
          out_last_d  = (i_q + 1'b1 == count_q);
          i_d         = i_q + 1'b1;
          if (i_q + 1'b1 == count_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = gbc_pkg::ST_IDLE;
          end else begin
            state_d = gbc_pkg::ST_RD_I;
          end
        end
      end

      default: state_d = gbc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbc_pkg::ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cell_w_q    <= gbc_pkg::SIZE_W'(1024);
      cell_h_q    <= gbc_pkg::SIZE_W'(1024);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gbc_pkg::CFG_CELL_WIDTH:  cell_w_q <= cfg_data_i;
          gbc_pkg::CFG_CELL_HEIGHT: cell_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    cur_q <= cur_d;
    if (out_load) begin
      out_tag_q   <= out_tag_d;
      out_hit_q   <= out_hit_d;
      out_ovf_q   <= out_ovf_d;
      out_empty_q <= out_empty_d;
      out_last_q  <= out_last_d;
    end
  end

  gbc_ram #(
    .WIDTH ($bits(gbc_pkg::box_rec_t)),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_hit_q, out_tag_q};
  assign m_axis_tuser  = {out_empty_q, out_ovf_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("box count beyond store depth");

  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && m_axis_tdata == '0 &&
                                            !m_axis_tuser[0]))
    else $error("empty run report carries data");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (count_q == '0 && !dropped_q))
    else $error("store not emptied after final report");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbc_pkg::ST_CMP_J) |-> (i_q < j_q && j_q < count_q))
    else $error("pair walk out of range");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbc_pkg::ST_CELL) |=> (count_q == $past(count_q)))
    else $error("store count moved during cell marking");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid broad-phase collision counter: box loads
// and run requests go in on the input stream, an in-bench model of the cell
// masks and pair overlaps predicts every report, and each report coming out is
// compared field by field while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BOXES      = 16;
  localparam int unsigned LOAD_LATENCY   = 20;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned N_PHASES       = 7;
  localparam int unsigned PHASE_ITEMS    = 10;

  typedef struct {
    logic                               cmd;
    logic [gbc_pkg::TAG_W-1:0]          tag;
    logic signed [gbc_pkg::COORD_W-1:0] left;
    logic signed [gbc_pkg::COORD_W-1:0] top;
    logic [gbc_pkg::SIZE_W-1:0]         width;
    logic [gbc_pkg::SIZE_W-1:0]         height;
    int unsigned                        gap;
  } box_req_t;

  typedef struct {
    logic [gbc_pkg::TAG_W-1:0]      tag;
    longint                         left;
    longint                         top;
    longint                         right;
    longint                         bottom;
    logic [gbc_pkg::GRID_CELLS-1:0] mask;
  } stored_box_t;

  typedef struct {
    logic [gbc_pkg::TAG_W-1:0] tag;
    logic [gbc_pkg::HIT_W-1:0] hits;
    logic                      overflow;
    logic                      empty_run;
    logic                      last;
  } box_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata = '0;
  logic [0:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_we_i = 1'b0;
  logic [gbc_pkg::CFG_IDX_W-1:0] cfg_idx_i = gbc_pkg::CFG_CELL_WIDTH;
  logic [gbc_pkg::SIZE_W-1:0]    cfg_data_i = '0;

  grid_broadphase_collision_counter #(
    .MAX_BOXES(MAX_BOXES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // model state, mirrors what the block holds
  logic [gbc_pkg::SIZE_W-1:0] cell_w = 15'd1024;
  logic [gbc_pkg::SIZE_W-1:0] cell_h = 15'd1024;
  stored_box_t       stored_boxes [MAX_BOXES];
  int unsigned       stored_cnt = 0;
  logic              dropped_seen = 1'b0;

  box_req_t          pending_q [$];
  box_report_t       expected_reports [$];
  box_req_t          cur_req;
  int unsigned       tx_wait = 0;
  int unsigned       rx_hold = 0;
  logic              long_hold_req = 1'b0;
  logic              long_hold_taken = 1'b0;
  int unsigned       quiet_cycles = 0;
  int unsigned       err_cnt = 0;
  int unsigned       reports_seen = 0;
  int unsigned       n_loads = 0;
  int unsigned       n_dropped = 0;
  int unsigned       n_runs = 0;
  int unsigned       n_empty_runs = 0;

  function automatic bit areas_overlap(stored_box_t a, longint l2, longint t2,
                                       longint r2, longint b2);
    longint lo_x, hi_x, lo_y, hi_y;
    lo_x = (a.left > l2) ? a.left : l2;
    hi_x = (a.right < r2) ? a.right : r2;
    lo_y = (a.top > t2) ? a.top : t2;
    hi_y = (a.bottom < b2) ? a.bottom : b2;
    return (lo_x < hi_x) && (lo_y < hi_y);
  endfunction

  task automatic predict_reports(input box_req_t r);
    stored_box_t               b;
    box_report_t               rep;
    logic [gbc_pkg::HIT_W-1:0] hits [MAX_BOXES];
    longint                    cx, cy;
    if (r.cmd == gbc_pkg::CMD_LOAD) begin
      n_loads++;
      if (stored_cnt >= MAX_BOXES) begin
        dropped_seen = 1'b1;
        n_dropped++;
      end else begin
        b.tag    = r.tag;
        b.left   = r.left;
        b.top    = r.top;
        b.right  = b.left + longint'(r.width);
        b.bottom = b.top + longint'(r.height);
        b.mask   = '0;
        for (int k = 0; k < gbc_pkg::GRID_CELLS; k++) begin
          cx = longint'(cell_w) * (k % 4);
          cy = longint'(cell_h) * (k / 4);
          if (areas_overlap(b, cx, cy, cx + longint'(cell_w), cy + longint'(cell_h)))
            b.mask[k] = 1'b1;
        end
        stored_boxes[stored_cnt] = b;
        stored_cnt++;
      end
    end else begin
      n_runs++;
      if (stored_cnt == 0) begin
        rep.tag       = '0;
        rep.hits      = '0;
        rep.overflow  = 1'b0;
        rep.empty_run = 1'b1;
        rep.last      = 1'b1;
        expected_reports.insert(expected_reports.size(), rep);
        n_empty_runs++;
      end else begin
        for (int i = 0; i < MAX_BOXES; i++) hits[i] = '0;
        for (int i = 0; i < stored_cnt; i++) begin
          for (int j = i + 1; j < stored_cnt; j++) begin
            if ((stored_boxes[i].mask & stored_boxes[j].mask) != '0 &&
                areas_overlap(stored_boxes[i], stored_boxes[j].left, stored_boxes[j].top,
                              stored_boxes[j].right, stored_boxes[j].bottom)) begin
              if (hits[i] < gbc_pkg::HIT_MAX) hits[i]++;
              if (hits[j] < gbc_pkg::HIT_MAX) hits[j]++;
            end
          end
        end
        for (int i = 0; i < stored_cnt; i++) begin
          rep.tag       = stored_boxes[i].tag;
          rep.hits      = hits[i];
          rep.overflow  = dropped_seen;
          rep.empty_run = 1'b0;
          rep.last      = (i == stored_cnt - 1);
          expected_reports.insert(expected_reports.size(), rep);
        end
      end
      stored_cnt   = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_report();
    box_report_t got, want;
    got.tag       = m_axis_tdata[15:0];
    got.hits      = m_axis_tdata[19:16];
    got.overflow  = m_axis_tuser[0];
    got.empty_run = m_axis_tuser[1];
    got.last      = m_axis_tlast;
    reports_seen++;
    if (expected_reports.size() == 0) begin
      $error("unexpected report, report_tag %0h hit_count %0d", got.tag, got.hits);
      err_cnt++;
    end else begin
      want = expected_reports.pop_front();
      if (got.tag !== want.tag) begin
        $error("report_tag expected %0h actual %0h", want.tag, got.tag);
        err_cnt++;
      end
      if (got.hits !== want.hits) begin
        $error("hit_count expected %0d actual %0d", want.hits, got.hits);
        err_cnt++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %0b actual %0b", want.overflow, got.overflow);
        err_cnt++;
      end
      if (got.empty_run !== want.empty_run) begin
        $error("empty_run expected %0b actual %0b", want.empty_run, got.empty_run);
        err_cnt++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b actual %0b", want.last, got.last);
        err_cnt++;
      end
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_reports(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && tx_wait >= pending_q[0].gap) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_req.height, cur_req.width, cur_req.top,
                            cur_req.left, cur_req.tag};
          s_axis_tuser  <= cur_req.cmd;
          tx_wait       <= 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (pending_q.size() != 0) tx_wait <= tx_wait + 1;
        end
      end
    end
  end

  // report monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready   <= 1'b1;
      rx_hold         <= 0;
      long_hold_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report();
      if (long_hold_req && !long_hold_taken && m_axis_tvalid) begin
        long_hold_taken <= 1'b1;
        rx_hold         <= LONG_HOLD;
        m_axis_tready   <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold       <= rx_hold - 1;
        m_axis_tready <= (rx_hold == 1);
      end else if (m_axis_tvalid && m_axis_tready) begin
        // every third stretch of twenty reports runs without stalls
        stall         = (((reports_seen / 20) % 3) == 0) ? 0 : draw_gap(1'b0);
        rx_hold       <= stall;
        m_axis_tready <= (stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [gbc_pkg::COORD_W-1:0] to_coord(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[gbc_pkg::COORD_W-1:0];
  endfunction

  function automatic logic [gbc_pkg::SIZE_W-1:0] to_size(longint v);
    if (v > 32767) return 15'h7fff;
    return v[gbc_pkg::SIZE_W-1:0];
  endfunction

  function automatic box_req_t box_load(logic [gbc_pkg::TAG_W-1:0] tag,
                                        logic [gbc_pkg::COORD_W-1:0] left,
                                        logic [gbc_pkg::COORD_W-1:0] top,
                                        logic [gbc_pkg::SIZE_W-1:0] w,
                                        logic [gbc_pkg::SIZE_W-1:0] h);
    box_req_t r;
    r.cmd    = gbc_pkg::CMD_LOAD;
    r.tag    = tag;
    r.left   = left;
    r.top    = top;
    r.width  = w;
    r.height = h;
    r.gap    = 0;
    return r;
  endfunction

  // boxes on a coarse lattice around the grid, so that overlaps and touching
  // edges are common; a few fully random and a few degenerate ones
  function automatic box_req_t rand_load();
    box_req_t    r;
    int unsigned kind;
    longint      ux, uy;
    ux = (cell_w >> 2) == 0 ? 1 : longint'(cell_w >> 2);
    uy = (cell_h >> 2) == 0 ? 1 : longint'(cell_h >> 2);
    kind = $urandom_range(0, 9);
    r = box_load(gbc_pkg::TAG_W'($urandom),
                 to_coord(ux * longint'($urandom_range(0, 17)) - ux),
                 to_coord(uy * longint'($urandom_range(0, 9)) - uy),
                 to_size(ux * longint'($urandom_range(1, 6))),
                 to_size(uy * longint'($urandom_range(1, 6))));
    if (kind == 0) begin
      r.left   = gbc_pkg::COORD_W'($urandom);
      r.top    = gbc_pkg::COORD_W'($urandom);
      r.width  = gbc_pkg::SIZE_W'($urandom);
      r.height = gbc_pkg::SIZE_W'($urandom);
    end else if (kind == 1) begin
      if ($urandom_range(0, 1) == 0) r.width = '0;
      else r.height = '0;
    end
    return r;
  endfunction

  task automatic push_req(input box_req_t r, input bit calm);
    r.gap = draw_gap(calm);
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic push_run(input bit calm);
    box_req_t r;
    r = box_load(gbc_pkg::TAG_W'($urandom), gbc_pkg::COORD_W'($urandom),
                 gbc_pkg::COORD_W'($urandom), gbc_pkg::SIZE_W'($urandom),
                 gbc_pkg::SIZE_W'($urandom));
    r.cmd = gbc_pkg::CMD_RUN;
    push_req(r, calm);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    repeat (LOAD_LATENCY) @(posedge clk_i);
  endtask

  task automatic set_cells(input logic [gbc_pkg::SIZE_W-1:0] w,
                           input logic [gbc_pkg::SIZE_W-1:0] h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gbc_pkg::CFG_CELL_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= gbc_pkg::CFG_CELL_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cell_w = w;
    cell_h = h;
  endtask

  initial begin : stimulus
    int unsigned phase_items, phase, n_boxes;
    bit          calm;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset cell sizes: empty run, edge cases around cell 0, boxes off the grid
    push_run(1'b0);
    push_req(box_load(16'hffff, 16'sd0, 16'sd0, 15'd1024, 15'd1024), 1'b0);
    push_req(box_load(16'h0000, 16'sd512, 16'sd512, 15'd1024, 15'd1024), 1'b0);
    push_req(box_load(16'h1234, 16'sd1024, 16'sd0, 15'd100, 15'd100), 1'b0);
    push_req(box_load(16'h0f0f, 16'sd100, 16'sd100, 15'd0, 15'd500), 1'b0);
    push_req(box_load(16'h8000, 16'sh8000, 16'sh8000, 15'd32767, 15'd32767), 1'b0);
    push_req(box_load(16'h7fff, -16'sd20000, -16'sd20000, 15'd1000, 15'd1000), 1'b0);
    push_req(box_load(16'h5a5a, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767), 1'b0);
    push_run(1'b0);
    wait_idle();

    // full store with counts at the maximum, then one load that gets dropped
    for (int i = 0; i < MAX_BOXES + 1; i++)
      push_req(box_load(gbc_pkg::TAG_W'(16'h0100 + i), 16'sd2000, 16'sd1000,
                        15'd300, 15'd300), 1'b0);
    push_run(1'b0);
    wait_idle();

    // receiver holds off on the first report while more loads wait behind the run
    long_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) push_req(rand_load(), 1'b1);
    push_run(1'b1);
    for (int i = 0; i < 6; i++) push_req(rand_load(), 1'b1);
    push_run(1'b1);
    wait_idle();

    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase % 7)
        0: set_cells(15'd0, 15'd1024);
        1: set_cells(15'd1024, 15'd0);
        2: set_cells(15'd32767, 15'd32767);
        3: set_cells(15'd1, 15'd1);
        4: set_cells(15'd16, 15'd16);
        5: set_cells(gbc_pkg::SIZE_W'($urandom_range(64, 2048)),
                     gbc_pkg::SIZE_W'($urandom_range(64, 2048)));
        default: set_cells(gbc_pkg::SIZE_W'($urandom_range(1, 32767)),
                           gbc_pkg::SIZE_W'($urandom_range(1, 32767)));
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: n_boxes = 0;
          1: n_boxes = $urandom_range(MAX_BOXES, MAX_BOXES + 3);
          default: n_boxes = $urandom_range(2, 8);
        endcase
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_boxes; i++) push_req(rand_load(), calm);
        push_run(calm);
        phase_items += n_boxes + 1;
      end
      wait_idle();
    end

    $display("checked %0d reports from %0d runs (%0d empty) over %0d loads, %0d dropped",
             reports_seen, n_runs, n_empty_runs, n_loads, n_dropped);
    $display("cell sizes swept through zero, one, 16, 1024, 32767 and random values");
    if (err_cnt == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== grid_broadphase_collision_counter.f =====
src/gbc_pkg.sv
src/gbc_ram.sv
src/gbc_overlap.sv
src/grid_broadphase_collision_counter.sv
verif/tb.sv
